// File: hdl/vrp_pkg.sv
`timescale 1ns / 1ps

package vrp_pkg;

  localparam int CoordW  = 40;  // holds the centered vertex after three turns
  localparam int ProdW   = CoordW + 16;
  localparam int SumW    = ProdW + 2;
  localparam int WideW   = CoordW + 1;
  localparam int FracW   = 14;
  localparam int HalfLsb = 8192;
  localparam int NumStg  = 9;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef coord_t [2:0]             vec_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic signed [WideW-1:0]  wide_t;
  typedef logic signed [31:0]       word_t;

  typedef enum logic [2:0] {
    REG_COS     = 3'd0,
    REG_SIN     = 3'd1,
    REG_MASK    = 3'd2,
    REG_CX      = 3'd3,
    REG_CY      = 3'd4,
    REG_CZ      = 3'd5,
    REG_HWIDTH  = 3'd6,
    REG_HHEIGHT = 3'd7
  } reg_idx_e;

  localparam logic signed [15:0] CosRst   = 16'sd16381;
  localparam logic signed [15:0] SinRst   = 16'sd286;
  localparam logic [2:0]         MaskRst  = 3'd7;
  localparam word_t              CxRst    = 32'sd11468800;
  localparam word_t              CyRst    = 32'sd13107200;
  localparam word_t              CzRst    = 32'sd6553600;
  localparam logic [14:0]        HwRst    = 15'd650;
  localparam logic [14:0]        HhRst    = 15'd400;

  // Coordinate lanes: 0 = x, 1 = y, 2 = z. Turns run about Y, then X, then Z.
  function automatic logic [1:0] turn_a_lane(input logic [1:0] turn);
    logic [1:0] lane;
    case (turn)
      2'd1:    lane = 2'd1;
      default: lane = 2'd0;
    endcase
    return lane;
  endfunction

  function automatic logic [1:0] turn_b_lane(input logic [1:0] turn);
    logic [1:0] lane;
    case (turn)
      2'd2:    lane = 2'd1;
      default: lane = 2'd2;
    endcase
    return lane;
  endfunction

  function automatic logic [1:0] turn_mask_bit(input logic [1:0] turn);
    logic [1:0] bit_idx;
    case (turn)
      2'd0:    bit_idx = 2'd1;
      2'd1:    bit_idx = 2'd0;
      default: bit_idx = 2'd2;
    endcase
    return bit_idx;
  endfunction

  function automatic word_t sat32(input wide_t v);
    word_t r;
    if (v > wide_t'(32'sh7fffffff)) begin
      r = 32'sh7fffffff;
    end else if (v < wide_t'(-33'sh80000000)) begin
      r = 32'sh80000000;
    end else begin
      r = word_t'(v);
    end
    return r;
  endfunction

endpackage

// File: hdl/vertex_rotate_project.sv
`timescale 1ns / 1ps

// Vertex rotate and orthographic project.
// Slave stream: one vertex per word, tdata = {point_z, point_y, point_x}.
// Master stream: one result per vertex,
//   tdata = {screen_y, screen_x, rot_z, rot_y, rot_x}, all signed Q16.16.
// Each vertex has the center subtracted, is turned about Y, X and Z as the
// axis mask enables, gets the center back and is saturated to 32 bits; the
// screen position is (x + half_width, half_height - y), saturated again.
// Nine register stages: center subtract, then per turn one multiply stage
// (four 40x16 products) and one round stage, then center add, then
// screen offset.
// Throughput: one vertex per cycle without stalls. Each stage holds a valid
// bit and loads whenever it is empty or the stage after it moves, so bubbles
// close up and tready stays high while any stage is free, also while a
// result waits. Reset clears all valid bits and loads the register defaults.
// Write the configuration port only while the pipeline is empty.
module vertex_rotate_project (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [95:0]  s_axis_tdata_i,   // point_x, point_y, point_z
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [159:0] m_axis_tdata_o    // rot_x, rot_y, rot_z, screen_x, screen_y
);
  import vrp_pkg::*;

  localparam int StRot = NumStg - 2;
  localparam int StScr = NumStg - 1;

  // configuration registers
  logic signed [15:0] cos_q, sin_q;
  logic [2:0]         mask_q;
  word_t              cx_q, cy_q, cz_q;
  logic [14:0]        hw_q, hh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q  <= CosRst;
      sin_q  <= SinRst;
      mask_q <= MaskRst;
      cx_q   <= CxRst;
      cy_q   <= CyRst;
      cz_q   <= CzRst;
      hw_q   <= HwRst;
      hh_q   <= HhRst;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_COS:     cos_q  <= cfg_data_i[15:0];
        REG_SIN:     sin_q  <= cfg_data_i[15:0];
        REG_MASK:    mask_q <= cfg_data_i[2:0];
        REG_CX:      cx_q   <= cfg_data_i;
        REG_CY:      cy_q   <= cfg_data_i;
        REG_CZ:      cz_q   <= cfg_data_i;
        REG_HWIDTH:  hw_q   <= cfg_data_i[14:0];
        REG_HHEIGHT: hh_q   <= cfg_data_i[14:0];
        default:     ;
      endcase
    end
  end

  // stage control: a stage loads when empty or when its successor moves
  logic [NumStg-1:0] vld_q, vld_in, en;

  assign vld_in = {vld_q[NumStg-2:0], s_axis_tvalid_i};

  always_comb begin
    en[NumStg-1] = !vld_q[NumStg-1] || m_axis_tready_i;
    for (int k = NumStg - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStg; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  assign s_axis_tready_o = en[0];

  // payload
  vec_t  vec_q [StRot];
  prod_t prod_q [3][4];
  word_t rot_q [3];
  word_t scr_q [2];

  // stage 0: subtract the center, exact in 40 bits
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      vec_q[0][0] <= coord_t'($signed(s_axis_tdata_i[31:0])) - coord_t'(cx_q);
      vec_q[0][1] <= coord_t'($signed(s_axis_tdata_i[63:32])) - coord_t'(cy_q);
      vec_q[0][2] <= coord_t'($signed(s_axis_tdata_i[95:64])) - coord_t'(cz_q);
    end
  end

  // three turns, each a multiply stage and a round stage
  for (genvar r = 0; r < 3; r++) begin : g_turn
    localparam logic [1:0] ALane = turn_a_lane(2'(r));
    localparam logic [1:0] BLane = turn_b_lane(2'(r));
    localparam logic [1:0] MBit  = turn_mask_bit(2'(r));
    localparam int         SMul  = 2 * r + 1;
    localparam int         SRnd  = 2 * r + 2;

    coord_t a_in, b_in;
    sum_t   sum_a, sum_b;
    vec_t   turned;

    assign a_in = vec_q[SMul-1][ALane];
    assign b_in = vec_q[SMul-1][BLane];

    always_ff @(posedge clk_i) begin
      if (en[SMul]) begin
        vec_q[SMul]  <= vec_q[SMul-1];
        prod_q[r][0] <= prod_t'(a_in) * prod_t'(cos_q);
        prod_q[r][1] <= prod_t'(b_in) * prod_t'(sin_q);
        prod_q[r][2] <= prod_t'(a_in) * prod_t'(sin_q);
        prod_q[r][3] <= prod_t'(b_in) * prod_t'(cos_q);
      end
    end

    // round to nearest, ties up: floor((sum + half) / 2^14)
    always_comb begin
      sum_a = sum_t'(prod_q[r][0]) - sum_t'(prod_q[r][1]) + sum_t'(HalfLsb);
      sum_b = sum_t'(prod_q[r][2]) + sum_t'(prod_q[r][3]) + sum_t'(HalfLsb);
      turned = vec_q[SMul];
      if (mask_q[MBit]) begin
        turned[ALane] = coord_t'(sum_a >>> FracW);
        turned[BLane] = coord_t'(sum_b >>> FracW);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[SRnd]) begin
        vec_q[SRnd] <= turned;
      end
    end
  end

  // add the center back and saturate to 32 bits
  always_ff @(posedge clk_i) begin
    if (en[StRot]) begin
      rot_q[0] <= sat32(wide_t'(vec_q[StRot-1][0]) + wide_t'(cx_q));
      rot_q[1] <= sat32(wide_t'(vec_q[StRot-1][1]) + wide_t'(cy_q));
      rot_q[2] <= sat32(wide_t'(vec_q[StRot-1][2]) + wide_t'(cz_q));
    end
  end

  // screen offset from the saturated coordinates
  word_t rot_hold [3];

  always_ff @(posedge clk_i) begin
    if (en[StScr]) begin
      rot_hold <= rot_q;
      scr_q[0] <= sat32(wide_t'(rot_q[0]) + wide_t'({hw_q, 16'h0000}));
      scr_q[1] <= sat32(wide_t'({hh_q, 16'h0000}) - wide_t'(rot_q[1]));
    end
  end

  assign m_axis_tvalid_o = vld_q[StScr];
  assign m_axis_tdata_o  = {scr_q[1], scr_q[0], rot_hold[2], rot_hold[1], rot_hold[0]};

  // pipeline occupancy tracks the handshakes
  logic s_acc, m_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign m_acc = m_axis_tvalid_o && m_axis_tready_i;

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&vld_q) && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while every stage is full and stalled");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && !m_acc) |=> ($countones(vld_q) == $past($countones(vld_q)) + 1))
    else $error("accepted word not held in the pipeline");

  a_count_dn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s_acc && m_acc) |=> ($countones(vld_q) + 1 == $past($countones(vld_q))))
    else $error("delivered word not removed from the pipeline");

endmodule
